>>> hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int DataW = 32;
  // Quotient bits resolved by the divider chain (2*n/d kept below 2^34)
  localparam int QuoW  = 34;

  localparam logic signed [DataW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_LE       = 4'd6,
    OP_GE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_INC      = 4'd10,
    OP_DEC      = 4'd11,
    OP_MIN      = 4'd12,
    OP_MAX      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    cmp;
    status_t                 status;
  } res_t;

  typedef struct packed {
    logic                    valid;
    op_t                     op;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
  } req_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    res_t             res;
    logic             neg;
    logic             use_div;
    logic [DataW-1:0] mag_a;
    logic [DataW-1:0] mag_b;
  } fast_t;

  typedef struct packed {
    logic               valid;
    op_t                op;
    res_t               res;
    logic               neg;
    logic               use_div;
    logic               ovf;
    logic [2*DataW-1:0] prod;
    logic [QuoW-1:0]    num;
    logic [DataW-1:0]   rem;
    logic [DataW-1:0]   den;
  } setup_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    res_t             res;
    logic             neg;
    logic             use_div;
    logic             ovf;
    logic [QuoW-1:0]  num;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] den;
    logic [QuoW-1:0]  quo;
  } dstage_t;

endpackage

>>> hdl/fpa_ifs.sv
// ----------------------------------------------------------------------------
// fpa_ifs
// Request and response channels of the fixed-point ALU.
// ----------------------------------------------------------------------------
interface fpa_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         req_type;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_raw;
  logic               compare_true;
  logic [1:0]         status;

  modport source (output valid, result_raw, compare_true, status, input ready);
  modport sink   (input valid, result_raw, compare_true, status, output ready);
endinterface

>>> hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Input register, simple operations, multiplier and divider setup.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  fpa_pkg::req_t    in_item,
  output fpa_pkg::dstage_t out_item
);
  import fpa_pkg::*;

  req_t   s0;
  fast_t  s1, s1_next;
  setup_t s2, s2_next;
  dstage_t s3, s3_next;

  logic signed [DataW-1:0] a, b, fi_hi;
  logic signed [DataW:0]   a33, b33, sum33;
  logic                    sum_ovf, gt, eq;
  logic [2*DataW-1:0]      numer, mul_q;
  logic                    mul_ovf;

  assign a   = s0.a;
  assign b   = s0.b;
  assign a33 = {a[DataW-1], a};
  assign b33 = {b[DataW-1], b};
  assign gt  = a > b;
  assign eq  = a == b;
  // Bits that from_int shifts out must all match the sign
  assign fi_hi = a >>> (DataW - 1 - FRAC_BITS);

  always_comb begin
    case (s0.op)
      OP_SUB:  sum33 = a33 - b33;
      OP_INC:  sum33 = a33 + 33'sd1;
      OP_DEC:  sum33 = a33 - 33'sd1;
      default: sum33 = a33 + b33;
    endcase
    sum_ovf = sum33[DataW] != sum33[DataW-1];
  end

  // Stage 1: everything but multiply and divide finishes here
  always_comb begin
    s1_next          = '0;
    s1_next.valid    = s0.valid;
    s1_next.op       = s0.op;
    s1_next.res      = '{value: '0, cmp: 1'b0, status: ST_OK};
    s1_next.neg      = a[DataW-1] ^ b[DataW-1];
    s1_next.use_div  = (s0.op == OP_DIV) && (b != '0);
    s1_next.mag_a    = a[DataW-1] ? (~a + 32'd1) : a;
    s1_next.mag_b    = b[DataW-1] ? (~b + 32'd1) : b;
    case (s0.op) inside
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (sum_ovf) begin
          s1_next.res.value  = sum33[DataW] ? VAL_MIN : VAL_MAX;
          s1_next.res.status = ST_OVF;
        end else begin
          s1_next.res.value = sum33[DataW-1:0];
        end
      end
      OP_DIV: begin
        // Divide by zero result; the divider result replaces it otherwise
        s1_next.res.status = ST_DZ;
        if (a[DataW-1]) begin
          s1_next.res.value = VAL_MIN;
        end else if (a != '0) begin
          s1_next.res.value = VAL_MAX;
        end
      end
      OP_GT: s1_next.res.cmp = gt;
      OP_LT: s1_next.res.cmp = !gt && !eq;
      OP_LE: s1_next.res.cmp = !gt;
      OP_GE: s1_next.res.cmp = gt || eq;
      OP_EQ: s1_next.res.cmp = eq;
      OP_NE: s1_next.res.cmp = !eq;
      OP_MIN: s1_next.res.value = (!gt && !eq) ? a : b;
      OP_MAX: s1_next.res.value = gt ? a : b;
      OP_FROM_INT: begin
        if (fi_hi != '0 && fi_hi != '1) begin
          s1_next.res.value  = a[DataW-1] ? VAL_MIN : VAL_MAX;
          s1_next.res.status = ST_OVF;
        end else begin
          s1_next.res.value = a <<< FRAC_BITS;
        end
      end
      OP_TO_INT: s1_next.res.value = a >>> FRAC_BITS;
      default: ;
    endcase
  end

  // Stage 2: magnitude product and divider operands
  assign numer = {{DataW{1'b0}}, s1.mag_a} << (FRAC_BITS + 1);

  always_comb begin
    s2_next         = '0;
    s2_next.valid   = s1.valid;
    s2_next.op      = s1.op;
    s2_next.res     = s1.res;
    s2_next.neg     = s1.neg;
    s2_next.use_div = s1.use_div;
    s2_next.prod    = s1.mag_a * s1.mag_b;
    s2_next.num     = numer[QuoW-1:0];
    s2_next.rem     = DataW'(numer[2*DataW-1:QuoW]);
    s2_next.den     = s1.mag_b;
    // Quotient bits above the chain's reach mean a saturated result
    s2_next.ovf     = DataW'(numer[2*DataW-1:QuoW]) >= s1.mag_b;
  end

  // Stage 3: round the product half away from zero and clamp
  assign mul_q   = (s2.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign mul_ovf = s2.neg ? (mul_q > 64'h8000_0000) : (mul_q > 64'h7FFF_FFFF);

  always_comb begin
    s3_next         = '0;
    s3_next.valid   = s2.valid;
    s3_next.op      = s2.op;
    s3_next.res     = s2.res;
    s3_next.neg     = s2.neg;
    s3_next.use_div = s2.use_div;
    s3_next.ovf     = s2.ovf;
    s3_next.num     = s2.num;
    s3_next.rem     = s2.rem;
    s3_next.den     = s2.den;
    if (s2.op == OP_MUL) begin
      if (mul_ovf) begin
        s3_next.res.value  = s2.neg ? VAL_MIN : VAL_MAX;
        s3_next.res.status = ST_OVF;
      end else begin
        s3_next.res.value = s2.neg ? (~mul_q[DataW-1:0] + 32'd1) : mul_q[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else if (en) begin
      s0 <= in_item;
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

  assign out_item = s3;

endmodule

>>> hdl/fpa_div_step.sv
// ----------------------------------------------------------------------------
// fpa_div_step
// One restoring division step: resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_div_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  fpa_pkg::dstage_t in_item,
  output fpa_pkg::dstage_t out_item
);
  import fpa_pkg::*;

  dstage_t          step_next;
  logic [DataW:0]   trial, diff;
  logic             take;

  assign trial = {in_item.rem, in_item.num[QuoW-1]};
  assign take  = trial >= {1'b0, in_item.den};
  assign diff  = trial - {1'b0, in_item.den};

  always_comb begin
    step_next     = in_item;
    step_next.rem = take ? diff[DataW-1:0] : trial[DataW-1:0];
    step_next.num = {in_item.num[QuoW-2:0], 1'b0};
    step_next.quo = {in_item.quo[QuoW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (en) begin
      out_item <= step_next;
    end
  end

endmodule

>>> hdl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Final stage: round the quotient, clamp, and pick the result.
// ----------------------------------------------------------------------------
module fpa_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  fpa_pkg::dstage_t in_item,
  output logic             out_valid,
  output fpa_pkg::res_t    out_res
);
  import fpa_pkg::*;

  logic [QuoW:0]   q_inc;
  logic [QuoW-1:0] q;
  logic            div_sat;
  res_t            div_res, res_next;

  // 2n/d plus one, halved: n/d rounded half up on magnitudes
  assign q_inc   = {1'b0, in_item.quo} + {{QuoW{1'b0}}, 1'b1};
  assign q       = q_inc[QuoW:1];
  assign div_sat = in_item.ovf ||
                   (in_item.neg ? (q > QuoW'(64'h8000_0000)) : (q > QuoW'(64'h7FFF_FFFF)));

  always_comb begin
    div_res = '{value: '0, cmp: 1'b0, status: ST_OK};
    if (div_sat) begin
      div_res.value  = in_item.neg ? VAL_MIN : VAL_MAX;
      div_res.status = ST_OVF;
    end else begin
      div_res.value = in_item.neg ? (~q[DataW-1:0] + 32'd1) : q[DataW-1:0];
    end
    res_next = (in_item.op == OP_DIV && in_item.use_div) ? div_res : in_item.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_item.valid;
    end
    if (en) begin
      out_res <= res_next;
    end
  end

  a_dz_only_div: assert property (@(posedge clk) disable iff (rst)
    (en && in_item.valid && in_item.op != OP_DIV) |=> (out_res.status != ST_DZ))
    else $error("divide-by-zero status on a non-divide beat");

  a_cmp_zero_value: assert property (@(posedge clk) disable iff (rst)
    (en && in_item.valid && (in_item.op == OP_GT || in_item.op == OP_LT ||
     in_item.op == OP_LE || in_item.op == OP_GE || in_item.op == OP_EQ ||
     in_item.op == OP_NE)) |=> (out_res.value == '0 && out_res.status == ST_OK))
    else $error("comparison beat carries a nonzero value or status");

endmodule

>>> hdl/fpa_skid.sv
// ----------------------------------------------------------------------------
// fpa_skid
// Two-entry output buffer; pipeline advances while the spare slot is free.
// ----------------------------------------------------------------------------
module fpa_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fpa_pkg::res_t push_res,
  output logic          room,
  fpa_rsp_if.source     rsp
);
  import fpa_pkg::*;

  logic out_v, spare_v;
  res_t out_d, spare_d;
  logic out_free;

  assign out_free = !out_v || rsp.ready;
  assign room     = !spare_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v   <= 1'b0;
      spare_v <= 1'b0;
    end else begin
      if (out_free) begin
        if (spare_v) begin
          out_v   <= 1'b1;
          out_d   <= spare_d;
          spare_v <= push;
          spare_d <= push_res;
        end else begin
          out_v <= push;
          out_d <= push_res;
        end
      end else if (push) begin
        // Hold the waiting beat, park the new one
        spare_v <= 1'b1;
        spare_d <= push_res;
      end
    end
  end

  assign rsp.valid        = out_v;
  assign rsp.result_raw   = out_d.value;
  assign rsp.compare_true = out_d.cmp;
  assign rsp.status       = out_d.status;

  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_v |-> out_v)
    else $error("spare slot filled while output slot empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    spare_v |-> !push)
    else $error("beat pushed into a full output buffer");

endmodule

>>> hdl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed 32-bit fixed-point ALU with saturation and rounding.
//
//   channel | role   | payload
//   --------+--------+---------------------------------------------
//   req     | sink   | req_type[3:0], operand_a[31:0], operand_b[31:0]
//   rsp     | source | result_raw[31:0], compare_true, status[1:0]
//
// One beat in and one beat out per cycle, sustained while rsp.ready keeps the spare slot free.
// A request passes through four front stages,
// 34 divider stages (one quotient bit each), the final stage and the output.
// Every operation takes the same path, so responses stay in request order.
// rst is synchronous and empties the pipeline and the output buffer.
// A stalled response parks in a spare slot; the pipeline holds only when
// that slot is full, and req.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  fpa_req_if.sink   req,
  fpa_rsp_if.source rsp
);
  import fpa_pkg::*;

  logic    en;
  req_t    req_item;
  dstage_t chain [0:QuoW];
  logic    back_valid;
  res_t    back_res;

  assign req.ready = en;
  assign req_item  = '{valid: req.valid, op: op_t'(req.req_type),
                       a: req.operand_a, b: req.operand_b};

  fpa_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_item  (req_item),
    .out_item (chain[0])
  );

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    fpa_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_item  (chain[k]),
      .out_item (chain[k+1])
    );
  end

  fpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_item   (chain[QuoW]),
    .out_valid (back_valid),
    .out_res   (back_res)
  );

  fpa_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (back_valid && en),
    .push_res (back_res),
    .room     (en),
    .rsp      (rsp)
  );

endmodule

>>> tb/tb_fixed_point_alu.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu
// Self-checking bench for the pipelined fixed-point ALU. Directed corner
// cases come first, then random requests with bursty idling on both channels,
// one long response hold-off and drain pauses. Each accepted request is
// predicted in exact 64-bit arithmetic and checked in order against the
// response channel.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu;
  import fpa_pkg::*;

  localparam int FRAC_BITS   = 8;
  localparam int CycleLimit  = 400000;
  localparam int LongHold    = 250;
  localparam int TailCycles  = 60;

  typedef struct {
    op_t                op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    res_t               res;
  } alu_case_t;

  class alu_result_check;
    alu_case_t pending[$];
    int        mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function res_t compute_alu_result(op_t op, logic signed [31:0] a,
                                      logic signed [31:0] b);
      res_t              r;
      longint            sa, sb, wide;
      longint unsigned   ma, mb, q;
      bit                neg, clip;
      sa = a;
      sb = b;
      ma = (sa < 0) ? -sa : sa;
      mb = (sb < 0) ? -sb : sb;
      neg = (sa < 0) != (sb < 0);
      r.value = '0;
      r.cmp = 1'b0;
      r.status = ST_OK;
      wide = 0;
      clip = 1'b1;
      case (op)
        OP_ADD: wide = sa + sb;
        OP_SUB: wide = sa - sb;
        OP_MUL: begin
          // round half away from zero on the magnitude
          q = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
          wide = neg ? -longint'(q) : longint'(q);
        end
        OP_DIV: begin
          if (sb == 0) begin
            clip = 1'b0;
            r.status = ST_DZ;
            r.value = (sa > 0) ? VAL_MAX : ((sa < 0) ? VAL_MIN : '0);
          end else begin
            q = (64'd2 * (ma << FRAC_BITS) + mb) / (64'd2 * mb);
            wide = neg ? -longint'(q) : longint'(q);
          end
        end
        OP_GT: begin clip = 1'b0; r.cmp = sa > sb; end
        OP_LT: begin clip = 1'b0; r.cmp = sa < sb; end
        OP_LE: begin clip = 1'b0; r.cmp = sa <= sb; end
        OP_GE: begin clip = 1'b0; r.cmp = sa >= sb; end
        OP_EQ: begin clip = 1'b0; r.cmp = sa == sb; end
        OP_NE: begin clip = 1'b0; r.cmp = sa != sb; end
        OP_INC: wide = sa + 1;
        OP_DEC: wide = sa - 1;
        OP_MIN: begin clip = 1'b0; r.value = (sa < sb) ? a : b; end
        OP_MAX: begin clip = 1'b0; r.value = (sa > sb) ? a : b; end
        OP_FROM_INT: wide = sa <<< FRAC_BITS;
        OP_TO_INT: begin clip = 1'b0; r.value = a >>> FRAC_BITS; end
      endcase
      if (clip) begin
        if (wide > longint'(VAL_MAX)) begin
          r.value = VAL_MAX;
          r.status = ST_OVF;
        end else if (wide < longint'(VAL_MIN)) begin
          r.value = VAL_MIN;
          r.status = ST_OVF;
        end else begin
          r.value = wide[31:0];
        end
      end
      return r;
    endfunction

    function void note_request(op_t op, logic signed [31:0] a, logic signed [31:0] b);
      alu_case_t c;
      c.op = op;
      c.a = a;
      c.b = b;
      c.res = compute_alu_result(op, a, b);
      pending.push_back(c);
    endfunction

    task report_mismatch(string msg);
      if (mismatch_count < 50) $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    task check_response(logic signed [31:0] value, logic cmp, logic [1:0] status);
      alu_case_t c;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value=%h cmp=%b status=%0d",
                                  value, cmp, status));
        return;
      end
      c = pending.pop_front();
      if (value !== c.res.value || cmp !== c.res.cmp || status !== c.res.status)
        report_mismatch($sformatf(
          "%s a=%h b=%h: got value=%h cmp=%b status=%0d, want value=%h cmp=%b status=%0d",
          c.op.name(), c.a, c.b, value, cmp, status,
          c.res.value, c.res.cmp, c.res.status));
    endtask
  endclass

  logic clk;
  logic rst;

  fpa_req_if req_ch();
  fpa_rsp_if rsp_ch();

  fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  alu_result_check results = new();

  bit tx_idle;
  bit rx_idle;
  bit hold_request;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      results.check_response(rsp_ch.result_raw, rsp_ch.compare_true, rsp_ch.status);
  end

  // Response side: long hold-off on request, otherwise random stall bursts while rx_idle is set.
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic drive_request(op_t op, logic signed [31:0] a, logic signed [31:0] b);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    do @(posedge clk); while (!req_ch.ready);
    results.note_request(op, a, b);
  endtask

  task automatic issue(op_t op, logic signed [31:0] a, logic signed [31:0] b);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    drive_request(op, a, b);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results.pending.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_operand();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      4, 5: v = $signed($urandom_range(0, 8191)) - 4096;
      6: begin
        case ($urandom_range(0, 7))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = 0;
          3: v = 1;
          4: v = -1;
          5: v = 256;
          6: v = -256;
          default: v = 128;
        endcase
      end
      7: v = $signed($urandom()) >>> $urandom_range(8, 24);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic random_request();
    op_t                op;
    logic signed [31:0] a, b;
    op = op_t'($urandom_range(0, 15));
    a = pick_operand();
    b = pick_operand();
    case ($urandom_range(0, 11))
      0: b = a;
      1: b = a + 1;
      2: b = 0;
      default: ;
    endcase
    issue(op, a, b);
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = OP_ADD;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_request = 1'b0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // corners: saturation, rounding ties, divide by zero, equal operands
    issue(OP_ADD, VAL_MAX, 1);
    issue(OP_ADD, VAL_MIN, -1);
    issue(OP_SUB, VAL_MIN, 1);
    issue(OP_SUB, 0, VAL_MIN);
    issue(OP_MUL, VAL_MAX, VAL_MAX);
    issue(OP_MUL, VAL_MIN, VAL_MIN);
    issue(OP_MUL, 1, 128);
    issue(OP_MUL, -1, 128);
    issue(OP_DIV, 5, 0);
    issue(OP_DIV, -5, 0);
    issue(OP_DIV, 0, 0);
    issue(OP_DIV, 1, 512);
    issue(OP_DIV, -1, 512);
    issue(OP_DIV, VAL_MIN, -1);
    issue(OP_GT, 7, 7);
    issue(OP_LT, VAL_MIN, VAL_MAX);
    issue(OP_LE, -3, -3);
    issue(OP_GE, VAL_MIN, VAL_MAX);
    issue(OP_EQ, VAL_MIN, VAL_MIN);
    issue(OP_NE, 42, 42);
    issue(OP_INC, VAL_MAX, 0);
    issue(OP_DEC, VAL_MIN, 0);
    issue(OP_MIN, -9, -9);
    issue(OP_MAX, VAL_MIN, VAL_MAX);
    issue(OP_FROM_INT, 32'sh0080_0000, 0);
    issue(OP_TO_INT, -1, 0);
    issue(OP_TO_INT, VAL_MIN, 0);
    wait_drained();

    // stall the response side for a long stretch while requests keep coming
    tx_idle = 1'b0;
    hold_request = 1'b1;
    repeat (100) random_request();

    for (int blk = 0; blk < 6; blk++) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      repeat (115) random_request();
      if (blk == 2) wait_drained();
    end

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (60) random_request();
    wait_drained();
    repeat (TailCycles) @(posedge clk);

    if (results.pending.size() != 0)
      results.report_mismatch($sformatf("%0d responses never arrived",
                                        results.pending.size()));
    if (results.mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
